FILE: design/neighbor_distance_table_top_defines.svh
// assertion macros for the neighbor distance table
`ifndef NEIGHBOR_DISTANCE_TABLE_TOP_DEFINES_SVH
`define NEIGHBOR_DISTANCE_TABLE_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define NDT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define NDT_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NDT_ASSERT(label, clk, rst_n, prop, msg)
`define NDT_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

FILE: design/ndt_pkg.sv
package ndt_pkg;
    localparam int IdW    = 32;
    localparam int PosW   = 24;
    localparam int DistW  = 16;
    localparam int SqW    = 51;
    localparam int RootW  = 26;
    localparam logic [DistW-1:0] DistMax = 16'hFFFF;

    typedef enum logic [2:0] {
        OP_INSERT = 3'd0,
        OP_BITMAP = 3'd1,
        OP_RANGE  = 3'd2,
        OP_WINNER = 3'd3,
        OP_COUNT  = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_SQ_X,
        ST_SQ_Y,
        ST_SQ_Z,
        ST_ROOT,
        ST_ROUND,
        ST_DIV,
        ST_APPLY,
        ST_INS,
        ST_OUT
    } state_t;
endpackage

FILE: design/neighbor_distance_table_top.sv
// channel | dir | tdata fields (low bit first)                               | width
// s_axis  | in  | operation, node_id, pos_x, pos_y, pos_z, bin_width,
//         |     | distance_low, distance_high                                 | 160
// m_axis  | out | esd_bitmap, bitmap_length, bitmap_clipped, found_distance,
//         |     | found_x, found_y, found_z, winner, entry_count,
//         |     | insert_dropped                                              | 176
// an insert walks the table, one entry read per cycle
// a query walks every entry and passes each valid one through one shared squarer
// and a radix-2 root unit, with a bin divide per entry on the second bitmap pass;
// the bitmap query takes two passes when any entry is valid
// reset clears state, valid bits, count and read-valid only; position storage holds no reset
// s_axis_tready is low from acceptance until the result item is taken
`include "neighbor_distance_table_top_defines.svh"
module neighbor_distance_table_top #(
    parameter int TABLE_ENTRIES = 32,
    parameter int BITMAP_BITS   = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // operation, node_id, pos_x, pos_y, pos_z, bin_width, distance_low, distance_high
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // esd_bitmap, bitmap_length, bitmap_clipped, found_distance, found_x, found_y,
    // found_z, winner, entry_count, insert_dropped, zero pad
    output logic [175:0] m_axis_tdata
);
    import ndt_pkg::*;

    localparam int IdxW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CntW = $clog2(TABLE_ENTRIES + 1);
    localparam int BlW  = $clog2(BITMAP_BITS + 1);

    // table storage
    logic [IdW-1:0]  mem_id [TABLE_ENTRIES];
    logic [PosW-1:0] mem_x  [TABLE_ENTRIES];
    logic [PosW-1:0] mem_y  [TABLE_ENTRIES];
    logic [PosW-1:0] mem_z  [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [CntW-1:0] count_reg, count_next;

    state_t state_reg, state_next;

    // captured item
    logic [2:0]       op_reg, op_next;
    logic [IdW-1:0]   id_reg, id_next;
    logic [PosW-1:0]  qx_reg, qx_next, qy_reg, qy_next, qz_reg, qz_next;
    logic [DistW-1:0] bw_reg, bw_next, lo_reg, lo_next, hi_reg, hi_next;

    // walk
    logic [IdxW-1:0] idx_reg, idx_next;
    logic            pass_reg, pass_next;     // bitmap: 0 finds max, 1 sets bins
    logic [IdW-1:0]  rid_reg;
    logic [PosW-1:0] rx_reg, ry_reg, rz_reg;
    logic            rvalid_reg;

    // insert search
    logic            slot_ok_reg, slot_ok_next, free_ok_reg, free_ok_next;
    logic [IdxW-1:0] slot_reg, slot_next, free_reg, free_next;

    // shared arithmetic
    logic [SqW-1:0]   acc_reg, acc_next;
    logic [SqW-1:0]   rem_reg, rem_next;
    logic [RootW-1:0] root_reg, root_next;
    logic [4:0]       step_reg, step_next;
    logic [DistW-1:0] dist_reg, dist_next;
    logic [DistW-1:0] quo_reg, quo_next;
    logic [DistW:0]   drem_reg, drem_next;

    // results
    logic [63:0]      bm_reg, bm_next;
    logic [BlW-1:0]   blen_reg, blen_next;
    logic             clip_reg, clip_next;
    logic             any_reg, any_next;
    logic [DistW-1:0] maxd_reg, maxd_next;
    logic             found_reg, found_next;
    logic [IdW-1:0]   fid_reg, fid_next;
    logic [DistW-1:0] fdist_reg, fdist_next;
    logic [PosW-1:0]  fx_reg, fx_next, fy_reg, fy_next, fz_reg, fz_next;
    logic             win_reg, win_next;
    logic             drop_reg, drop_next;

    logic             mem_we;
    logic [IdxW-1:0]  mem_wa;

    // shared squarer operand
    logic signed [PosW:0] diff;
    logic [PosW-1:0]      adiff;
    logic [2*PosW-1:0]    sq;
    logic [SqW-1:0]       trial;
    logic [RootW-1:0]     rn;
    logic [RootW+3:0]     mm;
    logic [2*RootW+7:0]   mm_sq;
    logic [SqW-1:0]       m2;
    logic [RootW-1:0]     nr;
    logic [DistW-1:0]     dsat;
    logic [DistW-1:0]     wdiv;
    logic [DistW:0]       dsub;
    logic [DistW-1:0]     bin_sh;
    logic                 last_idx;

    always_comb
    begin
        unique case (state_reg)
            ST_SQ_X: diff = $signed({qx_reg[PosW-1], qx_reg}) - $signed({rx_reg[PosW-1], rx_reg});
            ST_SQ_Y: diff = $signed({qy_reg[PosW-1], qy_reg}) - $signed({ry_reg[PosW-1], ry_reg});
            default: diff = $signed({qz_reg[PosW-1], qz_reg}) - $signed({rz_reg[PosW-1], rz_reg});
        endcase
        adiff = diff[PosW] ? PosW'(-diff) : diff[PosW-1:0];
    end
    assign sq = adiff * adiff;

    // radix-2 root: one result bit per step, from the top
    assign trial = (SqW'(root_reg) << (6'd2 * step_reg + 6'd2)) + (SqW'(1) << (6'd2 * step_reg));
    assign rn    = root_reg >> 4;
    assign mm    = {rn, 4'd8};
    assign mm_sq = mm * mm;
    assign m2    = mm_sq[SqW-1:0];
    assign wdiv  = (bw_reg == '0) ? DistW'(1) : bw_reg;
    assign dsub  = {drem_reg[DistW-1:0], dist_reg[step_reg[3:0]]} - {1'b0, wdiv};
    assign last_idx = (idx_reg == IdxW'(TABLE_ENTRIES - 1));

    always_comb
    begin
        if (acc_reg > m2)
            nr = rn + RootW'(1);
        else if (acc_reg == m2)
            nr = rn + RootW'(rn[0]);
        else
            nr = rn;
        dsat = (nr > RootW'(DistMax)) ? DistMax : nr[DistW-1:0];
        bin_sh = BlW'(blen_reg - BlW'(1)) - quo_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        op_next = op_reg; id_next = id_reg;
        qx_next = qx_reg; qy_next = qy_reg; qz_next = qz_reg;
        bw_next = bw_reg; lo_next = lo_reg; hi_next = hi_reg;
        idx_next = idx_reg; pass_next = pass_reg;
        slot_ok_next = slot_ok_reg; free_ok_next = free_ok_reg;
        slot_next = slot_reg; free_next = free_reg;
        acc_next = acc_reg; rem_next = rem_reg; root_next = root_reg;
        step_next = step_reg; dist_next = dist_reg;
        quo_next = quo_reg; drem_next = drem_reg;
        bm_next = bm_reg; blen_next = blen_reg; clip_next = clip_reg;
        any_next = any_reg; maxd_next = maxd_reg;
        found_next = found_reg; fid_next = fid_reg; fdist_next = fdist_reg;
        fx_next = fx_reg; fy_next = fy_reg; fz_next = fz_reg;
        win_next = win_reg; drop_next = drop_reg;
        valid_next = valid_reg; count_next = count_reg;
        mem_we = 1'b0; mem_wa = slot_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next = s_axis_tdata[2:0];
                    id_next = s_axis_tdata[34:3];
                    qx_next = s_axis_tdata[58:35];
                    qy_next = s_axis_tdata[82:59];
                    qz_next = s_axis_tdata[106:83];
                    bw_next = s_axis_tdata[122:107];
                    lo_next = s_axis_tdata[138:123];
                    hi_next = s_axis_tdata[154:139];
                    idx_next = '0; pass_next = 1'b0;
                    slot_ok_next = 1'b0; free_ok_next = 1'b0;
                    bm_next = '0; blen_next = '0; clip_next = 1'b0;
                    any_next = 1'b0; maxd_next = '0;
                    found_next = 1'b0; fdist_next = '0;
                    fx_next = '0; fy_next = '0; fz_next = '0;
                    win_next = (s_axis_tdata[2:0] == OP_WINNER);
                    drop_next = 1'b0;
                    unique case (s_axis_tdata[2:0])
                        OP_INSERT, OP_BITMAP, OP_RANGE, OP_WINNER: state_next = ST_READ;
                        default:                                   state_next = ST_OUT;
                    endcase
                end
            end
            ST_READ:
            begin
                // registered entry is now in r*_reg
                if (op_reg == OP_INSERT)
                begin
                    if (rvalid_reg)
                    begin
                        if (rid_reg == id_reg && !slot_ok_reg)
                        begin
                            slot_ok_next = 1'b1; slot_next = idx_reg;
                        end
                    end
                    else if (!free_ok_reg)
                    begin
                        free_ok_next = 1'b1; free_next = idx_reg;
                    end
                    if (last_idx) state_next = ST_INS;
                    else idx_next = idx_reg + IdxW'(1);
                end
                else if (rvalid_reg)
                begin
                    acc_next = '0;
                    state_next = ST_SQ_X;
                end
                else
                    state_next = ST_APPLY;
            end
            ST_SQ_X:
            begin
                acc_next = SqW'(sq);
                state_next = ST_SQ_Y;
            end
            ST_SQ_Y:
            begin
                acc_next = acc_reg + SqW'(sq);
                state_next = ST_SQ_Z;
            end
            ST_SQ_Z:
            begin
                acc_next = acc_reg + SqW'(sq);
                rem_next = acc_reg + SqW'(sq);
                root_next = '0;
                step_next = 5'(RootW - 1);
                state_next = ST_ROOT;
            end
            ST_ROOT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_next = rem_reg - trial;
                    root_next = {root_reg[RootW-2:0], 1'b1};
                end
                else
                    root_next = {root_reg[RootW-2:0], 1'b0};
                if (step_reg == '0) state_next = ST_ROUND;
                else step_next = step_reg - 5'd1;
            end
            ST_ROUND:
            begin
                dist_next = dsat;
                if (op_reg == OP_BITMAP && pass_reg)
                begin
                    quo_next = '0; drem_next = '0;
                    step_next = 5'(DistW - 1);
                    state_next = ST_DIV;
                end
                else
                    state_next = ST_APPLY;
            end
            ST_DIV:
            begin
                // restoring divide of dist by bin width, one bit per cycle
                if (!dsub[DistW])
                begin
                    drem_next = dsub;
                    quo_next = {quo_reg[DistW-2:0], 1'b1};
                end
                else
                begin
                    drem_next = {drem_reg[DistW-1:0], dist_reg[step_reg[3:0]]};
                    quo_next = {quo_reg[DistW-2:0], 1'b0};
                end
                if (step_reg == '0)
                begin
                    state_next = ST_APPLY;
                    // quotient of max distance sets the length once pass 0 has ended
                end
                else step_next = step_reg - 5'd1;
            end
            ST_APPLY:
            begin
                state_next = ST_READ;
                if (rvalid_reg)
                begin
                    unique case (op_reg)
                        OP_BITMAP:
                        begin
                            if (!pass_reg)
                            begin
                                any_next = 1'b1;
                                if (!any_reg || dist_reg > maxd_reg) maxd_next = dist_reg;
                            end
                            else if (17'(quo_reg) < 17'(blen_reg))
                                bm_next = bm_reg | (64'd1 << bin_sh[5:0]);
                        end
                        OP_RANGE:
                        begin
                            if (dist_reg >= lo_reg && dist_reg <= hi_reg &&
                                (!found_reg || rid_reg < fid_reg))
                            begin
                                found_next = 1'b1; fid_next = rid_reg;
                                fdist_next = dist_reg;
                                fx_next = rx_reg; fy_next = ry_reg; fz_next = rz_reg;
                            end
                        end
                        default:
                        begin
                            if (rid_reg > id_reg && dist_reg == lo_reg) win_next = 1'b0;
                        end
                    endcase
                end
                if (last_idx)
                begin
                    idx_next = '0;
                    if (op_reg == OP_BITMAP && !pass_reg)
                    begin
                        if (any_next)
                        begin
                            // divide max distance to get the length
                            dist_next = maxd_next;
                            quo_next = '0; drem_next = '0;
                            step_next = 5'(DistW - 1);
                            pass_next = 1'b1;
                            state_next = ST_DIV;
                            blen_next = '0;
                        end
                        else
                            state_next = ST_OUT;
                    end
                    else
                        state_next = ST_OUT;
                end
                else
                    idx_next = idx_reg + IdxW'(1);
                // length pass: divide result lands here with blen still zero
                if (op_reg == OP_BITMAP && pass_reg && blen_reg == '0)
                begin
                    if (17'(quo_reg) + 17'd1 > 17'(BITMAP_BITS))
                    begin
                        blen_next = BlW'(BITMAP_BITS); clip_next = 1'b1;
                    end
                    else
                        blen_next = BlW'(quo_reg + DistW'(1));
                    idx_next = '0;
                    bm_next = '0;
                    state_next = ST_READ;
                end
            end
            ST_INS:
            begin
                if (slot_ok_reg)
                begin
                    mem_we = 1'b1; mem_wa = slot_reg;
                end
                else if (free_ok_reg)
                begin
                    mem_we = 1'b1; mem_wa = free_reg;
                    valid_next[free_reg] = 1'b1;
                    count_next = count_reg + CntW'(1);
                end
                else
                    drop_next = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (m_axis_tready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // entry read, one per cycle
    always_ff @(posedge clk)
    begin
        rid_reg <= mem_id[idx_next];
        rx_reg  <= mem_x[idx_next];
        ry_reg  <= mem_y[idx_next];
        rz_reg  <= mem_z[idx_next];
        if (mem_we)
        begin
            mem_id[mem_wa] <= id_reg;
            mem_x[mem_wa]  <= qx_reg;
            mem_y[mem_wa]  <= qy_reg;
            mem_z[mem_wa]  <= qz_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= '0;
            count_reg <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            count_reg <= count_next;
            rvalid_reg <= valid_next[idx_next];
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg <= op_next; id_reg <= id_next;
        qx_reg <= qx_next; qy_reg <= qy_next; qz_reg <= qz_next;
        bw_reg <= bw_next; lo_reg <= lo_next; hi_reg <= hi_next;
        idx_reg <= idx_next; pass_reg <= pass_next;
        slot_ok_reg <= slot_ok_next; free_ok_reg <= free_ok_next;
        slot_reg <= slot_next; free_reg <= free_next;
        acc_reg <= acc_next; rem_reg <= rem_next; root_reg <= root_next;
        step_reg <= step_next; dist_reg <= dist_next;
        quo_reg <= quo_next; drem_reg <= drem_next;
        bm_reg <= bm_next; blen_reg <= blen_next; clip_reg <= clip_next;
        any_reg <= any_next; maxd_reg <= maxd_next;
        found_reg <= found_next; fid_reg <= fid_next; fdist_reg <= fdist_next;
        fx_reg <= fx_next; fy_reg <= fy_next; fz_reg <= fz_next;
        win_reg <= win_next; drop_reg <= drop_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata = {
        7'd0,
        drop_reg,
        6'(count_reg),
        win_reg,
        fz_reg, fy_reg, fx_reg,
        found_reg ? {1'b0, fdist_reg} : 17'h1FFFF,
        clip_reg,
        7'(blen_reg),
        bm_reg
    };

    `NDT_ASSERT(a_one_side, clk, rst_n, !(s_axis_tready && m_axis_tvalid), "ready while result pending")
    `NDT_ASSERT(a_count_bound, clk, rst_n, 32'(count_reg) <= 32'(TABLE_ENTRIES), "count overflow")
    `NDT_ASSERT(a_count_pop, clk, rst_n, 32'(count_reg) == 32'($countones(valid_reg)), "count mismatch")
    `NDT_ASSERT(a_out_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "result dropped")
endmodule
